// ===== src/assert_macros.svh =====
// assertion macros for the top rtl file of the look-at block
// expects signals clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("look-at property failed");
`define ASSERT_NEVER(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  !(cond)) else $error("look-at forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/lavm_pkg.sv =====
// widths, latencies, types and rounding, saturation and clamping helpers of the look-at view matrix block
// used by every rtl file of the block
`default_nettype none
package lavm_pkg;
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int VEC_W     = 18;
  localparam int NIN_W     = IN_W + 2;
  localparam int NM_W      = 30;
  localparam int NORM_MSB  = NM_W - 1;
  localparam int POS_W     = 6;
  localparam int SQ_W      = 2 * NM_W;
  localparam int RAD_W     = SQ_W + 2;
  localparam int ISQ_W     = RAD_W + 1;
  localparam int ISQ_STEPS = RAD_W / 2 + 1;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int NUM_W     = NM_W + FRAC_BITS + 1;
  localparam int NORM_LAT  = 5 + ISQ_STEPS + DIV_STEPS + 1;
  localparam int PROD_W    = 2 * VEC_W;
  localparam int DOTP_W    = VEC_W + IN_W;
  localparam int DOT_W     = DOTP_W + 2;
  localparam int TOP_LAT   = 2 * NORM_LAT + 5;

  localparam logic [DOT_W-1:0] RND_HALF = DOT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DOT_W-1:0] ONE_W = DOT_W'(1) << FRAC_BITS;
  localparam logic signed [VEC_W-1:0] ONE_FX = VEC_W'(1) << FRAC_BITS;
  localparam logic signed [DOT_W-1:0] S32_MAX = {{(DOT_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] S32_MIN = {{(DOT_W-IN_W+1){1'b1}}, {(IN_W-1){1'b0}}};

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [IN_W-1:0]  word_t;
  typedef logic signed [NIN_W-1:0] nin_t;

  // drop FRAC_BITS fraction bits, half away from zero
  function automatic logic signed [DOT_W-1:0] round_frac(input logic signed [DOT_W-1:0] x);
    logic [DOT_W-1:0] m;
    m = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
    m = (m + RND_HALF) >> FRAC_BITS;
    return x[DOT_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic word_t sat32(input logic signed [DOT_W-1:0] x);
    word_t r;
    if (x > S32_MAX) r = S32_MAX[IN_W-1:0];
    else if (x < S32_MIN) r = S32_MIN[IN_W-1:0];
    else r = x[IN_W-1:0];
    return r;
  endfunction

  function automatic vec_t clamp_unit(input logic signed [DOT_W-1:0] x);
    vec_t r;
    if (x > ONE_W) r = ONE_FX;
    else if (x < -ONE_W) r = -ONE_FX;
    else r = x[VEC_W-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== src/lavm_isqrt.sv =====
// pipelined integer square root, one result bit per register stage
// depends on lavm_pkg
`default_nettype none
module lavm_isqrt import lavm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root
);
  logic [ISQ_W-1:0] v_in  [ISQ_STEPS];
  logic [ISQ_W-1:0] r_in  [ISQ_STEPS];
  logic [ISQ_W-1:0] v_nxt [ISQ_STEPS];
  logic [ISQ_W-1:0] r_nxt [ISQ_STEPS];
  logic [ISQ_W-1:0] v_r   [ISQ_STEPS];
  logic [ISQ_W-1:0] r_r   [ISQ_STEPS];
  logic [ISQ_STEPS-1:0] vld_r;

  always_comb begin
    logic [ISQ_W-1:0] bitv;
    logic [ISQ_W-1:0] trial;
    v_in[0] = ISQ_W'(in_rad);
    r_in[0] = '0;
    for (int i = 1; i < ISQ_STEPS; i++) begin
      v_in[i] = v_r[i-1];
      r_in[i] = r_r[i-1];
    end
    for (int i = 0; i < ISQ_STEPS; i++) begin
      bitv  = ISQ_W'(1) << (RAD_W - 2 * i);
      trial = r_in[i] + bitv;
      if (v_in[i] >= trial) begin
        v_nxt[i] = v_in[i] - trial;
        r_nxt[i] = (r_in[i] >> 1) + bitv;
      end else begin
        v_nxt[i] = v_in[i];
        r_nxt[i] = r_in[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[ISQ_STEPS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ISQ_STEPS; i++) begin
      v_r[i] <= v_nxt[i];
      r_r[i] <= r_nxt[i];
    end
  end

  assign out_valid = vld_r[ISQ_STEPS-1];
  assign out_root  = r_r[ISQ_STEPS-1][ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== src/lavm_div.sv =====
// pipelined restoring divider, rounded unit-scale quotient of magnitude over norm
// depends on lavm_pkg
`default_nettype none
module lavm_div import lavm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NM_W-1:0]   in_mag,
  input  logic [ROOT_W-1:0] in_den,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo
);
  logic [NUM_W-1:0]  rem_in  [DIV_STEPS];
  logic [ROOT_W-1:0] den_in  [DIV_STEPS];
  logic [QUO_W-1:0]  quo_in  [DIV_STEPS];
  logic [NUM_W-1:0]  rem_nxt [DIV_STEPS];
  logic [QUO_W-1:0]  quo_nxt [DIV_STEPS];
  logic [NUM_W-1:0]  rem_r   [DIV_STEPS];
  logic [ROOT_W-1:0] den_r   [DIV_STEPS];
  logic [QUO_W-1:0]  quo_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_r;

  always_comb begin
    logic [NUM_W-1:0] dsh;
    logic             ge;
    // half the divisor added up front gives round half up
    rem_in[0] = (NUM_W'(in_mag) << FRAC_BITS) + NUM_W'(in_den >> 1);
    den_in[0] = in_den;
    quo_in[0] = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_in[k] = rem_r[k-1];
      den_in[k] = den_r[k-1];
      quo_in[k] = quo_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dsh        = NUM_W'(den_in[k]) << (QUO_W - 1 - k);
      ge         = rem_in[k] >= dsh;
      rem_nxt[k] = ge ? rem_in[k] - dsh : rem_in[k];
      quo_nxt[k] = {quo_in[k][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[DIV_STEPS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_in[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_quo   = quo_r[DIV_STEPS-1];
endmodule
`default_nettype wire

// ===== src/lavm_norm.sv =====
// pipelined 3-vector normalizer: scale, sum of squares, root, three dividers
// depends on lavm_pkg, lavm_isqrt and lavm_div
`default_nettype none
module lavm_norm import lavm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  nin_t in_vec [3],
  output logic out_valid,
  output vec_t out_vec [3]
);
  typedef struct packed {
    logic [2:0][NM_W-1:0] m;
    logic [2:0]           neg;
    logic                 zero;
  } npay_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } nsgn_t;

  logic [4:0] vld_r;

  logic [2:0][NIN_W-1:0] mag1_nxt, mag1_r, mag2_r;
  logic [2:0]            neg1_nxt, neg1_r, neg2_r;
  logic [NIN_W-1:0]      or_c;
  logic [POS_W-1:0]      pos_nxt, pos2_r;
  logic                  zero2_r;
  npay_t                 pay3_nxt, pay3_r, pay4_r, pay5_r;
  logic [2:0][SQ_W-1:0]  sq_nxt, sq4_r;
  logic [RAD_W-1:0]      sum5_r;
  npay_t                 pay_dl [ISQ_STEPS];
  nsgn_t                 sgn_dl [DIV_STEPS];
  logic                  rt_vld;
  logic [ROOT_W-1:0]     root;
  logic [2:0]            quo_vld;
  logic [QUO_W-1:0]      quo [3];
  vec_t                  out_vec_nxt [3];
  vec_t                  out_vec_r [3];
  logic                  out_vld_r;
  nsgn_t                 sgn_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = in_vec[i][NIN_W-1];
      mag1_nxt[i] = neg1_nxt[i] ? NIN_W'(-in_vec[i]) : NIN_W'(in_vec[i]);
    end
  end

  // msb of the or equals msb of the largest magnitude
  always_comb begin
    or_c    = mag1_r[0] | mag1_r[1] | mag1_r[2];
    pos_nxt = '0;
    for (int i = 0; i < NIN_W; i++) begin
      if (or_c[i]) pos_nxt = POS_W'(i);
    end
  end

  always_comb begin
    logic [NIN_W-1:0] sh;
    pay3_nxt.neg  = neg2_r;
    pay3_nxt.zero = zero2_r;
    for (int i = 0; i < 3; i++) begin
      if (pos2_r >= POS_W'(NORM_MSB)) sh = mag2_r[i] >> (pos2_r - POS_W'(NORM_MSB));
      else sh = mag2_r[i] << (POS_W'(NORM_MSB) - pos2_r);
      pay3_nxt.m[i] = sh[NM_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = SQ_W'(pay3_r.m[i]) * SQ_W'(pay3_r.m[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    mag1_r  <= mag1_nxt;
    neg1_r  <= neg1_nxt;
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    pos2_r  <= pos_nxt;
    zero2_r <= (or_c == '0);
    pay3_r  <= pay3_nxt;
    pay4_r  <= pay3_r;
    sq4_r   <= sq_nxt;
    pay5_r  <= pay4_r;
    sum5_r  <= RAD_W'(sq4_r[0]) + RAD_W'(sq4_r[1]) + RAD_W'(sq4_r[2]);
    pay_dl[0] <= pay5_r;
    for (int k = 1; k < ISQ_STEPS; k++) pay_dl[k] <= pay_dl[k-1];
    sgn_dl[0] <= '{neg: pay_dl[ISQ_STEPS-1].neg, zero: pay_dl[ISQ_STEPS-1].zero};
    for (int k = 1; k < DIV_STEPS; k++) sgn_dl[k] <= sgn_dl[k-1];
  end

  lavm_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[4]),
    .in_rad    (sum5_r),
    .out_valid (rt_vld),
    .out_root  (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    lavm_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rt_vld),
      .in_mag    (pay_dl[ISQ_STEPS-1].m[g]),
      .in_den    (root),
      .out_valid (quo_vld[g]),
      .out_quo   (quo[g])
    );
  end

  assign sgn_a = sgn_dl[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sgn_a.zero) out_vec_nxt[i] = '0;
      else if (sgn_a.neg[i]) out_vec_nxt[i] = -VEC_W'(quo[i]);
      else out_vec_nxt[i] = VEC_W'(quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else out_vld_r <= &quo_vld;
  end

  always_ff @(posedge clk) begin
    out_vec_r <= out_vec_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_vec   = out_vec_r;
endmodule
`default_nettype wire

// ===== src/look_at_view_matrix_top.sv =====
// look-at view matrix unit: two normalizers in series, then cross and dot products
// depends on lavm_pkg, lavm_norm and assert_macros.svh
//
// usage:
//   drive in_eye_* and in_target_* (signed Q16.16) and raise start for one
//   cycle; the beat is taken at a clock edge with start high and busy low.
//   busy is high only while rst_n is low, so a new beat may be offered in
//   every cycle.
//   out_valid strobes for one cycle per beat with the rotation rows
//   (out_side_*, out_upv_*, out_back_*) and the translations (out_trans_*).
//   pipeline: from the accepting edge to out_valid a beat passes 115
//   register stages: two normalizers of 55 stages each (32-stage square
//   root and 17-stage divider, one bit per stage) plus five stages of
//   setup, cross products, dot products and output registers.
//   throughput: one beat per cycle, results in input order.
//   reset: synchronous, active low; clears every valid bit, in-flight beats
//   are dropped. the receiver cannot stall, results are never held.
`default_nettype none
`include "assert_macros.svh"
module look_at_view_matrix_top import lavm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  word_t in_eye_x,
  input  word_t in_eye_y,
  input  word_t in_eye_z,
  input  word_t in_target_x,
  input  word_t in_target_y,
  input  word_t in_target_z,
  output logic  out_valid,
  output vec_t  out_side_x,
  output vec_t  out_side_y,
  output vec_t  out_side_z,
  output vec_t  out_upv_x,
  output vec_t  out_upv_y,
  output vec_t  out_upv_z,
  output vec_t  out_back_x,
  output vec_t  out_back_y,
  output vec_t  out_back_z,
  output word_t out_trans_x,
  output word_t out_trans_y,
  output word_t out_trans_z
);
  logic  acc;
  logic  v1_r;
  word_t eye1_r [3];
  nin_t  d1_r [3];
  vec_t  fa [3];
  logic  fa_vld;
  nin_t  sc_vec [3];
  vec_t  sv [3];
  logic  s_vld;
  word_t eye_dl [2*NORM_LAT][3];
  vec_t  f_dl [NORM_LAT][3];
  logic [3:0] x_vld_r;

  logic signed [PROD_W-1:0] cp_nxt [6];
  logic signed [PROD_W-1:0] cp_r [6];
  logic signed [DOTP_W-1:0] sp_nxt [3];
  logic signed [DOTP_W-1:0] fp_nxt [3];
  logic signed [DOTP_W-1:0] sp_r [3];
  logic signed [DOTP_W-1:0] fp_r [3];
  logic signed [DOTP_W-1:0] up_nxt [3];
  logic signed [DOTP_W-1:0] up_r [3];
  vec_t  s1_r [3];
  vec_t  f1_r [3];
  word_t e1_r [3];
  vec_t  u_nxt [3];
  vec_t  s2_r [3];
  vec_t  u2_r [3];
  vec_t  f2_r [3];
  word_t e2_r [3];
  vec_t  s3_r [3];
  vec_t  u3_r [3];
  vec_t  f3_r [3];
  word_t tx_nxt, tz_nxt, ty_nxt;
  word_t tx2_r, tz2_r, tx3_r, tz3_r;
  vec_t  side_r [3];
  vec_t  upv_r [3];
  vec_t  back_r [3];
  word_t trans_r [3];

  assign busy = !rst_n;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= acc;
  end

  always_ff @(posedge clk) begin
    eye1_r[0] <= in_eye_x;
    eye1_r[1] <= in_eye_y;
    eye1_r[2] <= in_eye_z;
    d1_r[0]   <= NIN_W'(in_target_x) - NIN_W'(in_eye_x);
    d1_r[1]   <= NIN_W'(in_target_y) - NIN_W'(in_eye_y);
    d1_r[2]   <= NIN_W'(in_target_z) - NIN_W'(in_eye_z);
  end

  lavm_norm u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_vec    (d1_r),
    .out_valid (fa_vld),
    .out_vec   (fa)
  );

  // forward cross (0,1,0)
  assign sc_vec[0] = -NIN_W'(fa[2]);
  assign sc_vec[1] = '0;
  assign sc_vec[2] = NIN_W'(fa[0]);

  lavm_norm u_norm_side (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fa_vld),
    .in_vec    (sc_vec),
    .out_valid (s_vld),
    .out_vec   (sv)
  );

  always_ff @(posedge clk) begin
    eye_dl[0] <= eye1_r;
    for (int k = 1; k < 2*NORM_LAT; k++) eye_dl[k] <= eye_dl[k-1];
    f_dl[0] <= fa;
    for (int k = 1; k < NORM_LAT; k++) f_dl[k] <= f_dl[k-1];
  end

  // cross product terms of u = s x f, and the s and f dot terms
  always_comb begin
    cp_nxt[0] = sv[1] * f_dl[NORM_LAT-1][2];
    cp_nxt[1] = sv[2] * f_dl[NORM_LAT-1][1];
    cp_nxt[2] = sv[2] * f_dl[NORM_LAT-1][0];
    cp_nxt[3] = sv[0] * f_dl[NORM_LAT-1][2];
    cp_nxt[4] = sv[0] * f_dl[NORM_LAT-1][1];
    cp_nxt[5] = sv[1] * f_dl[NORM_LAT-1][0];
    for (int i = 0; i < 3; i++) begin
      sp_nxt[i] = sv[i] * eye_dl[2*NORM_LAT-1][i];
      fp_nxt[i] = f_dl[NORM_LAT-1][i] * eye_dl[2*NORM_LAT-1][i];
    end
  end

  always_comb begin
    u_nxt[0] = clamp_unit(round_frac(DOT_W'(cp_r[0]) - DOT_W'(cp_r[1])));
    u_nxt[1] = clamp_unit(round_frac(DOT_W'(cp_r[2]) - DOT_W'(cp_r[3])));
    u_nxt[2] = clamp_unit(round_frac(DOT_W'(cp_r[4]) - DOT_W'(cp_r[5])));
    tx_nxt = sat32(-round_frac(DOT_W'(sp_r[0]) + DOT_W'(sp_r[1]) + DOT_W'(sp_r[2])));
    tz_nxt = sat32(round_frac(DOT_W'(fp_r[0]) + DOT_W'(fp_r[1]) + DOT_W'(fp_r[2])));
    for (int i = 0; i < 3; i++) up_nxt[i] = u2_r[i] * e2_r[i];
    ty_nxt = sat32(-round_frac(DOT_W'(up_r[0]) + DOT_W'(up_r[1]) + DOT_W'(up_r[2])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) x_vld_r <= '0;
    else x_vld_r <= {x_vld_r[2:0], s_vld};
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    sp_r  <= sp_nxt;
    fp_r  <= fp_nxt;
    s1_r  <= sv;
    f1_r  <= f_dl[NORM_LAT-1];
    e1_r  <= eye_dl[2*NORM_LAT-1];
    s2_r  <= s1_r;
    u2_r  <= u_nxt;
    f2_r  <= f1_r;
    e2_r  <= e1_r;
    tx2_r <= tx_nxt;
    tz2_r <= tz_nxt;
    up_r  <= up_nxt;
    s3_r  <= s2_r;
    u3_r  <= u2_r;
    f3_r  <= f2_r;
    tx3_r <= tx2_r;
    tz3_r <= tz2_r;
    side_r <= s3_r;
    upv_r  <= u3_r;
    for (int i = 0; i < 3; i++) back_r[i] <= -f3_r[i];
    trans_r[0] <= tx3_r;
    trans_r[1] <= ty_nxt;
    trans_r[2] <= tz3_r;
  end

  assign out_valid   = x_vld_r[3];
  assign out_side_x  = side_r[0];
  assign out_side_y  = side_r[1];
  assign out_side_z  = side_r[2];
  assign out_upv_x   = upv_r[0];
  assign out_upv_y   = upv_r[1];
  assign out_upv_z   = upv_r[2];
  assign out_back_x  = back_r[0];
  assign out_back_y  = back_r[1];
  assign out_back_z  = back_r[2];
  assign out_trans_x = trans_r[0];
  assign out_trans_y = trans_r[1];
  assign out_trans_z = trans_r[2];

  `ASSERT_CLK(a_latency, out_valid |-> $past(start && !busy, TOP_LAT))
  `ASSERT_NEVER(a_side_y_zero, out_valid && (out_side_y != '0))
  `ASSERT_NEVER(a_up_needs_side, out_valid && (out_side_x == '0) && (out_side_z == '0) && ((out_upv_x != '0) || (out_upv_y != '0) || (out_upv_z != '0)))
  `ASSERT_NEVER(a_zero_fwd, out_valid && (out_back_x == '0) && (out_back_y == '0) && (out_back_z == '0) && ((out_side_x != '0) || (out_side_z != '0) || (out_trans_z != '0)))
endmodule
`default_nettype wire
